### sv/lbpe_pkg.sv
// ----------------------------------------------------------------------------
// LED blink pattern engine package
// Shared constants, codes, the blink word table and the control structs.
// ----------------------------------------------------------------------------
package lbpe_pkg;

  localparam int SLOT_COUNT  = 8;
  localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int MAX_RESULTS = 16;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  localparam logic [2:0] SEL_OFF = 3'd0;
  localparam logic [2:0] SEL_ON  = 3'd1;

  function automatic logic [15:0] blink_word(input logic [2:0] sel);
    logic [15:0] word;
    case (sel)
      3'd2:    word = 16'h2121;
      3'd3:    word = 16'h2424;
      3'd4:    word = 16'h1F23;
      3'd5:    word = 16'h1F42;
      3'd6:    word = 16'h1F62;
      3'd7:    word = 16'h2D2D;
      default: word = 16'h0000;
    endcase
    return word;
  endfunction

  typedef struct packed {
    logic              idle;
    logic              scan;
    logic              stop_wr;
    logic              sel_wr;
    logic              tick_a;
    logic              tick_b;
    logic              flush;
    logic [SLOT_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic  in_valid;
    logic  stall;
    logic  twice;
    mode_t mode;
  } status_t;

endpackage

### sv/lbpe_if.sv
// ----------------------------------------------------------------------------
// LED blink pattern engine channels
// Valid/ready channels for input items, pin writes and the polarity register.
// ----------------------------------------------------------------------------
interface lbpe_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] pin;
  logic [2:0] pattern_select;

  modport source(output valid, output mode, output pin, output pattern_select, input ready);
  modport sink(input valid, input mode, input pin, input pattern_select, output ready);
endinterface

interface lbpe_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] write_pin;
  logic       pin_level;
  logic       last;

  modport source(output valid, output write_pin, output pin_level, output last, input ready);
  modport sink(input valid, input write_pin, input pin_level, input last, output ready);
endinterface

interface lbpe_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### sv/lbpe_ctrl.sv
// ----------------------------------------------------------------------------
// LED blink pattern engine controller
// Sequences the slot walk, the pin writes and the final flush for each item.
// ----------------------------------------------------------------------------
module lbpe_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  lbpe_pkg::status_t status,
  output lbpe_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DISPATCH = 8'b0000_0010,
    S_SCAN     = 8'b0000_0100,
    S_STOP_WR  = 8'b0000_1000,
    S_SEL_WR   = 8'b0001_0000,
    S_TICK_A   = 8'b0010_0000,
    S_TICK_B   = 8'b0100_0000,
    S_FLUSH    = 8'b1000_0000
  } state_t;

  localparam logic [lbpe_pkg::SLOT_W-1:0] LAST_IDX =
    lbpe_pkg::SLOT_W'(lbpe_pkg::SLOT_COUNT - 1);

  state_t                      state;
  state_t                      state_next;
  logic [lbpe_pkg::SLOT_W-1:0] idx;
  logic [lbpe_pkg::SLOT_W-1:0] idx_next;
  logic                        idx_last;

  assign idx_last = (idx == LAST_IDX);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (status.in_valid) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        idx_next = '0;
        unique case (status.mode) inside
          lbpe_pkg::MODE_TICK:  state_next = S_TICK_A;
          lbpe_pkg::MODE_START,
          lbpe_pkg::MODE_STOP:  state_next = S_SCAN;
          default:              state_next = S_FLUSH;
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (idx_last) begin
          state_next = S_STOP_WR;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_STOP_WR: begin
        cmd.stop_wr = 1'b1;
        if (!status.stall) begin
          state_next = S_SEL_WR;
        end
      end
      S_SEL_WR: begin
        cmd.sel_wr = 1'b1;
        if (!status.stall) begin
          state_next = S_FLUSH;
        end
      end
      S_TICK_A: begin
        cmd.tick_a = 1'b1;
        if (!status.stall) begin
          if (status.twice) begin
            state_next = S_TICK_B;
          end else if (idx_last) begin
            state_next = S_FLUSH;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      S_TICK_B: begin
        cmd.tick_b = 1'b1;
        if (!status.stall) begin
          if (idx_last) begin
            state_next = S_FLUSH;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_TICK_A;
          end
        end
      end
      S_FLUSH: begin
        cmd.flush = 1'b1;
        if (!status.stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

### sv/lbpe_datapath.sv
// ----------------------------------------------------------------------------
// LED blink pattern engine datapath
// Slot table, per-slot update logic, polarity register and the write queue.
// ----------------------------------------------------------------------------
module lbpe_datapath (
  input  logic              clk,
  input  logic              rst,
  input  lbpe_pkg::cmd_t    cmd,
  output lbpe_pkg::status_t status,
  lbpe_item_if.sink         item,
  lbpe_result_if.source     result,
  lbpe_cfg_if.sink          cfg
);

  logic [7:0]  slot_pin     [lbpe_pkg::SLOT_COUNT];
  logic [15:0] slot_pattern [lbpe_pkg::SLOT_COUNT];
  logic [7:0]  slot_count   [lbpe_pkg::SLOT_COUNT];

  logic                           active_high;
  lbpe_pkg::mode_t                item_mode;
  logic [7:0]                     item_pin;
  logic [2:0]                     item_sel;
  logic                           found;
  logic                           free_found;
  logic [lbpe_pkg::SLOT_W-1:0]    free_idx;
  logic [lbpe_pkg::RES_CNT_W-1:0] res_cnt;
  logic                           pend_valid;
  logic [7:0]                     pend_pin;
  logic                           pend_level;
  logic                           out_valid;
  logic [7:0]                     out_pin;
  logic                           out_level;
  logic                           out_last;

  logic        accept;
  logic [7:0]  cur_pin;
  logic [15:0] cur_pat;
  logic [7:0]  cur_cnt;
  logic [7:0]  cnt_inc;
  logic [7:0]  cnt_wrap;
  logic        low_hit;
  logic        high_hit;
  logic        slot_busy;
  logic        scan_hit;
  logic        scan_free;
  logic        blink_sel;
  logic        fill;
  logic        tick_upd;
  logic [7:0]  tick_cnt;
  logic [15:0] tick_pat;
  logic        push_req;
  logic        push_lit;
  logic [7:0]  push_pin;
  logic        push_level;
  logic        push_ok;
  logic        push_do;
  logic        flush_ok;
  logic        stall;
  logic        res_room;
  logic        out_load;

  assign item.ready   = cmd.idle;
  assign accept       = item.valid && item.ready;
  assign cfg.ready    = 1'b1;

  assign result.valid     = out_valid;
  assign result.write_pin = out_pin;
  assign result.pin_level = out_level;
  assign result.last      = out_last;

  assign cur_pin   = slot_pin[cmd.idx];
  assign cur_pat   = slot_pattern[cmd.idx];
  assign cur_cnt   = slot_count[cmd.idx];
  assign cnt_inc   = cur_cnt + 8'd1;
  assign cnt_wrap  = {cnt_inc[7:4] + 4'd1, 4'd0};
  assign low_hit   = (cnt_inc[3:0] == cur_pat[3:0]);
  assign high_hit  = (cnt_wrap[7:4] == cur_pat[7:4]);
  assign slot_busy = (cur_pin != 8'd0);

  assign scan_hit  = cmd.scan && (cur_pin == item_pin);
  assign scan_free = scan_hit || (cur_pin == 8'd0);
  assign blink_sel = (item_sel != lbpe_pkg::SEL_OFF) && (item_sel != lbpe_pkg::SEL_ON);
  assign fill      = cmd.sel_wr && (item_mode == lbpe_pkg::MODE_START) && blink_sel
                     && free_found;
  assign tick_upd  = cmd.tick_a && !stall && slot_busy;

  always_comb begin
    tick_cnt = cnt_inc;
    tick_pat = cur_pat;
    if (low_hit) begin
      if (high_hit) begin
        tick_cnt = 8'd0;
        tick_pat = {cur_pat[7:0], cur_pat[15:8]};
      end else begin
        tick_cnt = cnt_wrap;
      end
    end
  end

  always_comb begin
    push_req = 1'b0;
    push_lit = 1'b0;
    push_pin = item_pin;
    if (cmd.tick_a) begin
      push_req = slot_busy && low_hit;
      push_lit = cnt_wrap[4];
      push_pin = cur_pin;
    end else if (cmd.tick_b) begin
      push_req = 1'b1;
      push_pin = cur_pin;
    end else if (cmd.stop_wr) begin
      push_req = (item_mode == lbpe_pkg::MODE_STOP) || found;
    end else if (cmd.sel_wr) begin
      push_req = (item_mode == lbpe_pkg::MODE_START) && !blink_sel;
      push_lit = (item_sel == lbpe_pkg::SEL_ON);
    end
  end

  assign push_level = push_lit ? active_high : ~active_high;
  assign flush_ok   = !out_valid || result.ready;
  assign push_ok    = !pend_valid || flush_ok;
  assign push_do    = push_req && push_ok;
  assign stall      = (push_req && !push_ok) || (cmd.flush && pend_valid && !flush_ok);
  assign res_room   = (res_cnt < lbpe_pkg::RES_CNT_W'(lbpe_pkg::MAX_RESULTS));
  assign out_load   = pend_valid && ((push_do && res_room) || (cmd.flush && flush_ok));

  assign status.in_valid = item.valid;
  assign status.stall    = stall;
  assign status.twice    = slot_busy && low_hit && high_hit;
  assign status.mode     = item_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < lbpe_pkg::SLOT_COUNT; i++) begin
        slot_pin[i] <= 8'd0;
      end
    end else if (scan_hit) begin
      slot_pin[cmd.idx] <= 8'd0;
    end else if (fill) begin
      slot_pin[free_idx] <= item_pin;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_hit) begin
      slot_pattern[cmd.idx] <= 16'd0;
      slot_count[cmd.idx]   <= 8'd0;
    end else if (fill) begin
      slot_pattern[free_idx] <= lbpe_pkg::blink_word(item_sel);
      slot_count[free_idx]   <= 8'd0;
    end else if (tick_upd) begin
      slot_pattern[cmd.idx] <= tick_pat;
      slot_count[cmd.idx]   <= tick_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_high <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      active_high <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_mode  <= lbpe_pkg::MODE_NONE;
      found      <= 1'b0;
      free_found <= 1'b0;
      free_idx   <= '0;
    end else if (accept) begin
      item_mode  <= lbpe_pkg::mode_t'(item.mode);
      found      <= 1'b0;
      free_found <= 1'b0;
    end else if (cmd.scan) begin
      if (scan_hit) begin
        found <= 1'b1;
      end
      if (scan_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmd.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_pin <= item.pin;
      item_sel <= item.pattern_select;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      res_cnt    <= '0;
    end else begin
      if (accept) begin
        res_cnt <= '0;
      end else if (push_do && res_room) begin
        if (pend_valid) begin
          out_pin   <= pend_pin;
          out_level <= pend_level;
          out_last  <= 1'b0;
        end
        pend_valid <= 1'b1;
        pend_pin   <= push_pin;
        pend_level <= push_level;
        res_cnt    <= res_cnt + 1'b1;
      end else if (cmd.flush && pend_valid && flush_ok) begin
        out_pin    <= pend_pin;
        out_level  <= pend_level;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
      end
    end
  end

endmodule

### sv/led_blink_pattern_engine.sv
// ----------------------------------------------------------------------------
// LED blink pattern engine
// Keeps a table of blink slots and turns start, stop and tick items into pin
// writes with the configured output polarity.
// ----------------------------------------------------------------------------
// The item channel carries mode, pin and pattern_select; one transfer is one
// command. The result channel carries one pin write per transfer, and last
// marks the final write caused by an item. An item that causes no write gives
// no result transfer. The cfg channel sets the polarity bit and is always
// ready; write it only while the block is idle (not enforced by the block).
// Each item is decoded, then the slot table is walked one slot per cycle unless
// a stalled receiver holds a tick walk, and a final flush step releases the
// last write. A start or stop walks the slots and then passes its stop-write and
// select-write steps; a tick updates each slot, with an extra write step for
// each slot that ends its pattern period. An unused mode skips the walk.
// The single slot-table read port sets this pace.
// Writes pass through a one-entry holding stage and an output register, so
// a stalled receiver holds the walk only when both are full; the next item is
// accepted while the last write still waits in the output register.
// Reset empties every slot, clears the polarity bit and drops pending writes.
// ----------------------------------------------------------------------------
module led_blink_pattern_engine (
  input  logic          clk,
  input  logic          rst,
  lbpe_item_if.sink     item,
  lbpe_result_if.source result,
  lbpe_cfg_if.sink      cfg
);

  lbpe_pkg::cmd_t    cmd;
  lbpe_pkg::status_t status;

  lbpe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  lbpe_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .item   (item),
    .result (result),
    .cfg    (cfg)
  );

endmodule
